[design/packed_2bit_symbol_range_count_defines.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the packed 2-bit symbol range counter
// Concurrent property wrappers that the counter's design file uses for its checks.
// ----------------------------------------------------------------------------
`ifndef PACKED_2BIT_SYMBOL_RANGE_COUNT_DEFINES_SVH
`define PACKED_2BIT_SYMBOL_RANGE_COUNT_DEFINES_SVH

`ifndef ASSERT_OFF
`define P2SRC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("p2src same-cycle check failed");
`define P2SRC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("p2src next-cycle check failed");
`else
`define P2SRC_ASSERT_SAME(label, clk, rst, ante, cons)
`define P2SRC_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

[design/p2src_pkg.sv]
// ----------------------------------------------------------------------------
// Packed 2-bit symbol range counter package
// Fixed widths, operation codes and shared types.
// ----------------------------------------------------------------------------
package p2src_pkg;

   localparam int SYMBOL_BITS      = 2;
   localparam int SYMBOLS_PER_BYTE = 4;
   localparam int BYTE_BITS        = 8;
   localparam int INDEX_SHIFT      = 2;
   localparam int MATCH_COUNT_BITS = 3;

   typedef logic [SYMBOL_BITS-1:0]      symbol_type;
   typedef logic [BYTE_BITS-1:0]        packed_byte_type;
   typedef logic [MATCH_COUNT_BITS-1:0] match_count_type;
   typedef logic                        opcode_type;

   localparam opcode_type OP_BEGIN = 1'b0;
   localparam opcode_type OP_DATA  = 1'b1;

endpackage

[design/p2src_byte_match.sv]
// ----------------------------------------------------------------------------
// Packed byte match counter
// Counts the symbols of one packed byte that equal the query symbol and whose
// position lies in the half-open query range.
// ----------------------------------------------------------------------------
module p2src_byte_match #(
   parameter int POSITION_BITS = 40
) (
   input  p2src_pkg::symbol_type                               query_symbol,
   input  logic [POSITION_BITS-1:0]                            query_start,
   input  logic [POSITION_BITS-1:0]                            query_end,
   input  p2src_pkg::packed_byte_type                          packed_byte,
   input  logic [POSITION_BITS-p2src_pkg::INDEX_SHIFT-1:0]     byte_addr,
   output p2src_pkg::match_count_type                          match_count
);

   localparam int SymBits   = p2src_pkg::SYMBOL_BITS;
   localparam int LaneCount = p2src_pkg::SYMBOLS_PER_BYTE;
   localparam int LaneBits  = p2src_pkg::INDEX_SHIFT;
   localparam int CountBits = p2src_pkg::MATCH_COUNT_BITS;

   logic [LaneCount-1:0] lane_hit;

   always_comb begin
      logic [POSITION_BITS-1:0] pos;
      p2src_pkg::symbol_type    sym;
      for (int k = 0; k < LaneCount; k++) begin
         sym         = packed_byte[SymBits*k +: SymBits];
         pos         = {byte_addr, LaneBits'(k)};
         lane_hit[k] = (sym == query_symbol) && (pos >= query_start) && (pos < query_end);
      end
   end

   assign match_count = CountBits'($countones(lane_hit));

endmodule

[design/packed_2bit_symbol_range_count.sv]
// A beat is registered in the input register on acceptance, and the result of a last
// data beat then passes to the output register once that register is free or read.
// Throughput: one beat per cycle while no result waits; the running count updates
// once per data beat. A waiting result holds a last data beat in the input
// register, and the beats behind it wait with it. Reset is synchronous and active
// high; it empties the pipeline and clears the query and the running count to zero.
// ----------------------------------------------------------------------------
// Packed 2-bit symbol range counter
// Counts occurrences of one 2-bit symbol in a position range of a packed byte
// stream and reports the count, less the sentinel, on the last byte.
// ----------------------------------------------------------------------------
`include "packed_2bit_symbol_range_count_defines.svh"

module packed_2bit_symbol_range_count #(
   parameter int POSITION_BITS = 40
) (
   input  logic                                            clock,
   input  logic                                            reset,
   input  logic                                            req_valid,
   output logic                                            req_ready,
   input  p2src_pkg::opcode_type                           req_opcode,
   input  p2src_pkg::symbol_type                           req_symbol_rank,
   input  logic [POSITION_BITS-1:0]                        req_range_start,
   input  logic [POSITION_BITS-1:0]                        req_range_end,
   input  logic [POSITION_BITS-1:0]                        req_primary_position,
   input  p2src_pkg::packed_byte_type                      req_packed_byte,
   input  logic [POSITION_BITS-p2src_pkg::INDEX_SHIFT-1:0] req_byte_addr,
   input  logic                                            req_last_byte,
   output logic                                            rsp_valid,
   input  logic                                            rsp_ready,
   output logic [POSITION_BITS-1:0]                        rsp_occurrence_count
);

   localparam int PosBits   = POSITION_BITS;
   localparam int IdxBits   = POSITION_BITS - p2src_pkg::INDEX_SHIFT;
   localparam int CountBits = p2src_pkg::MATCH_COUNT_BITS;
   localparam int WideBits  = POSITION_BITS + 1;

   // Input register.
   logic                            s1_valid_ff, s1_valid_in;
   p2src_pkg::opcode_type           s1_opcode_ff;
   p2src_pkg::symbol_type           s1_symbol_ff;
   logic [PosBits-1:0]              s1_start_ff;
   logic [PosBits-1:0]              s1_end_ff;
   logic [PosBits-1:0]              s1_primary_ff;
   p2src_pkg::packed_byte_type      s1_byte_ff;
   logic [IdxBits-1:0]              s1_index_ff;
   logic                            s1_last_ff;

   // Query and accumulator state.
   p2src_pkg::symbol_type           query_symbol_ff, query_symbol_in;
   logic [PosBits-1:0]              query_start_ff, query_start_in;
   logic [PosBits-1:0]              query_end_ff, query_end_in;
   logic                            sentinel_ff, sentinel_in;
   logic [PosBits-1:0]              count_ff, count_in;

   // Result register.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [PosBits-1:0]              rsp_count_ff, rsp_count_in;

   logic                            req_fire;
   logic                            s1_is_begin;
   logic                            s1_is_final;
   logic                            s1_advance;
   p2src_pkg::match_count_type      match_count;
   p2src_pkg::match_count_type      match_less_one;
   logic [WideBits-1:0]             sum_full;
   logic [WideBits-1:0]             dec_full;
   logic [PosBits-1:0]              sat_count;
   logic [PosBits-1:0]              final_count;
   logic                            total_zero;

   assign s1_is_begin = (s1_opcode_ff == p2src_pkg::OP_BEGIN);
   assign s1_is_final = (s1_opcode_ff == p2src_pkg::OP_DATA) && s1_last_ff;
   assign s1_advance  = s1_valid_ff && (!s1_is_final || !rsp_valid_ff || rsp_ready);
   assign req_ready   = !s1_valid_ff || s1_advance;
   assign req_fire    = req_valid && req_ready;

   p2src_byte_match #(
      .POSITION_BITS (POSITION_BITS)
   ) u_match (
      .query_symbol (query_symbol_ff),
      .query_start  (query_start_ff),
      .query_end    (query_end_ff),
      .packed_byte  (s1_byte_ff),
      .byte_addr    (s1_index_ff),
      .match_count  (match_count)
   );

   // The decremented total is formed beside the sum so that no subtract follows the add.
   assign match_less_one = match_count - CountBits'(1);
   assign sum_full   = {1'b0, count_ff} + WideBits'(match_count);
   assign dec_full   = {1'b0, count_ff}
                     + {{(WideBits-CountBits){match_less_one[CountBits-1]}}, match_less_one};
   assign sat_count  = sum_full[PosBits] ? {PosBits{1'b1}} : sum_full[PosBits-1:0];
   assign total_zero = (count_ff == '0) && (match_count == '0);

   always_comb begin
      if (!sentinel_ff) begin
         final_count = sat_count;
      end else if (sum_full[PosBits]) begin
         final_count = {{(PosBits-1){1'b1}}, 1'b0};
      end else if (total_zero) begin
         final_count = '0;
      end else begin
         final_count = dec_full[PosBits-1:0];
      end
   end

   always_comb begin
      s1_valid_in     = s1_valid_ff;
      query_symbol_in = query_symbol_ff;
      query_start_in  = query_start_ff;
      query_end_in    = query_end_ff;
      sentinel_in     = sentinel_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_count_in    = rsp_count_ff;

      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (s1_advance) begin
         s1_valid_in = 1'b0;
      end

      if (s1_advance) begin
         if (s1_is_begin) begin
            query_symbol_in = s1_symbol_ff;
            query_start_in  = s1_start_ff;
            query_end_in    = s1_end_ff;
            sentinel_in     = (s1_symbol_ff == '0) && (s1_primary_ff >= s1_start_ff)
                              && (s1_primary_ff < s1_end_ff);
            count_in        = '0;
         end else if (s1_last_ff) begin
            count_in     = '0;
            rsp_valid_in = 1'b1;
            rsp_count_in = final_count;
         end else begin
            count_in = sat_count;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff     <= 1'b0;
         query_symbol_ff <= '0;
         query_start_ff  <= '0;
         query_end_ff    <= '0;
         sentinel_ff     <= 1'b0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         s1_valid_ff     <= s1_valid_in;
         query_symbol_ff <= query_symbol_in;
         query_start_ff  <= query_start_in;
         query_end_ff    <= query_end_in;
         sentinel_ff     <= sentinel_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_opcode_ff  <= req_opcode;
         s1_symbol_ff  <= req_symbol_rank;
         s1_start_ff   <= req_range_start;
         s1_end_ff     <= req_range_end;
         s1_primary_ff <= req_primary_position;
         s1_byte_ff    <= req_packed_byte;
         s1_index_ff   <= req_byte_addr;
         s1_last_ff    <= req_last_byte;
      end
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_occurrence_count = rsp_count_ff;

   `P2SRC_ASSERT_NEXT(a_final_gives_rsp, clock, reset, s1_advance && s1_is_final, rsp_valid_ff)
   `P2SRC_ASSERT_NEXT(a_begin_clears_count, clock, reset, s1_advance && s1_is_begin, count_ff == '0)
   `P2SRC_ASSERT_SAME(a_sentinel_only_symbol_zero, clock, reset, sentinel_ff, query_symbol_ff == '0)

endmodule

[verif/tb_packed_2bit_symbol_range_count.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the packed 2-bit symbol range counter
// A short table of directed beats covers the range edges, the sentinel rule and
// the extreme positions. Random queries with noise and broken sequences follow.
// Results are checked against a cycle-free occurrence predictor or typed counts.
// ----------------------------------------------------------------------------
module tb_packed_2bit_symbol_range_count;

   localparam int          POSITION_BITS = 40;
   localparam int          INDEX_BITS    = POSITION_BITS - p2src_pkg::INDEX_SHIFT;
   localparam int          RANDOM_BEATS  = 750;
   localparam int          CYCLE_LIMIT   = 200000;
   localparam int          IDLE_PERCENT  = 16;
   localparam logic [POSITION_BITS-1:0] POS_MAX   = {POSITION_BITS{1'b1}};
   localparam logic [INDEX_BITS-1:0]    INDEX_MAX = {INDEX_BITS{1'b1}};

   typedef struct {
      p2src_pkg::opcode_type      opcode;
      p2src_pkg::symbol_type      symbol;
      logic [POSITION_BITS-1:0]   range_start;
      logic [POSITION_BITS-1:0]   range_end;
      logic [POSITION_BITS-1:0]   primary;
      p2src_pkg::packed_byte_type data;
      logic [INDEX_BITS-1:0]      index;
      logic                       last;
      bit                         has_typed;
      logic [POSITION_BITS-1:0]   typed_count;
   } beat_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   p2src_pkg::opcode_type      req_opcode = p2src_pkg::OP_BEGIN;
   p2src_pkg::symbol_type      req_symbol_rank = '0;
   logic [POSITION_BITS-1:0]   req_range_start = '0;
   logic [POSITION_BITS-1:0]   req_range_end = '0;
   logic [POSITION_BITS-1:0]   req_primary_position = '0;
   p2src_pkg::packed_byte_type req_packed_byte = '0;
   logic [INDEX_BITS-1:0]      req_byte_addr = '0;
   logic                       req_last_byte = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [POSITION_BITS-1:0]   rsp_occurrence_count;

   p2src_pkg::symbol_type      query_symbol;
   logic [POSITION_BITS-1:0]   query_start;
   logic [POSITION_BITS-1:0]   query_end;
   logic [POSITION_BITS-1:0]   query_primary;
   logic [POSITION_BITS-1:0]   running_tally;

   logic [POSITION_BITS-1:0]   pending_counts[$];
   logic [POSITION_BITS-1:0]   oldest_count;
   beat_type                   directed_beats[$];
   bit                         steady = 1'b0;
   int                         error_count = 0;
   int                         beats_sent = 0;
   int                         queries_begun = 0;
   int                         data_beats = 0;
   int                         counts_checked = 0;
   int                         cycle_count = 0;

   packed_2bit_symbol_range_count #(
      .POSITION_BITS(POSITION_BITS)
   ) u_top (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_symbol_rank      (req_symbol_rank),
      .req_range_start      (req_range_start),
      .req_range_end        (req_range_end),
      .req_primary_position (req_primary_position),
      .req_packed_byte      (req_packed_byte),
      .req_byte_addr        (req_byte_addr),
      .req_last_byte        (req_last_byte),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_occurrence_count (rsp_occurrence_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [POSITION_BITS-1:0] random_position();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[POSITION_BITS-1:0];
   endfunction

   function automatic logic [INDEX_BITS-1:0] random_index();
      logic [63:0] r;
      r = {$urandom, $urandom};
      return r[INDEX_BITS-1:0];
   endfunction

   // Fields that a beat does not use carry random values.
   function automatic beat_type begin_beat(p2src_pkg::symbol_type sym,
                                           logic [POSITION_BITS-1:0] lo,
                                           logic [POSITION_BITS-1:0] hi,
                                           logic [POSITION_BITS-1:0] prim);
      beat_type b;
      b.opcode      = p2src_pkg::OP_BEGIN;
      b.symbol      = sym;
      b.range_start = lo;
      b.range_end   = hi;
      b.primary     = prim;
      b.data        = p2src_pkg::packed_byte_type'($urandom);
      b.index       = random_index();
      b.last        = 1'($urandom);
      b.has_typed   = 1'b0;
      b.typed_count = '0;
      return b;
   endfunction

   function automatic beat_type data_beat(p2src_pkg::packed_byte_type data,
                                          logic [INDEX_BITS-1:0] idx,
                                          logic last, bit has_typed = 1'b0,
                                          logic [POSITION_BITS-1:0] typed_count = '0);
      beat_type b;
      b.opcode      = p2src_pkg::OP_DATA;
      b.symbol      = p2src_pkg::symbol_type'($urandom);
      b.range_start = random_position();
      b.range_end   = random_position();
      b.primary     = random_position();
      b.data        = data;
      b.index       = idx;
      b.last        = last;
      b.has_typed   = has_typed;
      b.typed_count = typed_count;
      return b;
   endfunction

   function automatic void predict_occurrences(input beat_type b);
      logic [63:0]              hit_total;
      logic [63:0]              pos;
      logic [POSITION_BITS-1:0] count;
      if (b.opcode == p2src_pkg::OP_BEGIN) begin
         query_symbol  = b.symbol;
         query_start   = b.range_start;
         query_end     = b.range_end;
         query_primary = b.primary;
         running_tally = '0;
         queries_begun++;
         return;
      end
      data_beats++;
      hit_total = 0;
      for (int k = 0; k < p2src_pkg::SYMBOLS_PER_BYTE; k++) begin
         pos = 64'(b.index) * p2src_pkg::SYMBOLS_PER_BYTE + k;
         if (b.data[2*k +: p2src_pkg::SYMBOL_BITS] == query_symbol
             && 64'(query_start) <= pos && pos < 64'(query_end))
            hit_total++;
      end
      if (64'(running_tally) > 64'(POS_MAX) - hit_total)
         running_tally = POS_MAX;
      else
         running_tally = running_tally + POSITION_BITS'(hit_total);
      if (!b.last)
         return;
      count = running_tally;
      if (query_symbol == p2src_pkg::symbol_type'(0) && query_start <= query_primary
          && query_primary < query_end && count != 0)
         count = count - 1'b1;
      pending_counts.push_back(b.has_typed ? b.typed_count : count);
      running_tally = '0;
   endfunction

   task automatic send_beat(input beat_type b);
      while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid            <= 1'b1;
      req_opcode           <= b.opcode;
      req_symbol_rank      <= b.symbol;
      req_range_start      <= b.range_start;
      req_range_end        <= b.range_end;
      req_primary_position <= b.primary;
      req_packed_byte      <= b.data;
      req_byte_addr        <= b.index;
      req_last_byte        <= b.last;
      @(posedge clock);
      while (!req_ready)
         @(posedge clock);
      predict_occurrences(b);
      beats_sent++;
   endtask

   // A well-formed query: begin, bytes around the range, last byte. A broken
   // one drops its last byte or is cut short by a fresh begin.
   task automatic send_query(input bit broken);
      p2src_pkg::symbol_type      sym;
      logic [INDEX_BITS-1:0]      base;
      logic [POSITION_BITS-1:0]   lo;
      logic [POSITION_BITS-1:0]   hi;
      logic [POSITION_BITS-1:0]   prim;
      logic [INDEX_BITS-1:0]      idx;
      p2src_pkg::packed_byte_type data;
      int                         span;
      int                         nbytes;
      int                         extra;
      sym = p2src_pkg::symbol_type'($urandom_range(3));
      case ($urandom_range(15))
         0:       base = random_index();
         1:       base = INDEX_MAX - INDEX_BITS'($urandom_range(20));
         default: base = INDEX_BITS'($urandom_range(2000));
      endcase
      lo   = POSITION_BITS'({base, 2'b00}) + POSITION_BITS'($urandom_range(7));
      span = $urandom_range(48);
      case ($urandom_range(15))
         0:       hi = lo - POSITION_BITS'($urandom_range(20, 1));
         1:       begin
            lo = random_position();
            hi = random_position();
         end
         default: hi = lo + POSITION_BITS'(span);
      endcase
      prim = $urandom_range(1) ? lo + POSITION_BITS'($urandom_range(span)) : random_position();
      send_beat(begin_beat(sym, lo, hi, prim));
      nbytes = $urandom_range(14, 1);
      idx    = base - INDEX_BITS'($urandom_range(1));
      for (int i = 0; i < nbytes; i++) begin
         data = ($urandom_range(3) == 0) ? {p2src_pkg::SYMBOLS_PER_BYTE{sym}}
                                         : p2src_pkg::packed_byte_type'($urandom);
         send_beat(data_beat(data, idx, (i == nbytes - 1) && !broken));
         case ($urandom_range(19))
            0:       idx = random_index();
            1, 2:    ;
            default: idx = idx + 1'b1;
         endcase
         if (broken && i == nbytes / 2 && $urandom_range(1))
            break;
      end
      // The query stays loaded after a count, so later bytes start a new one.
      if (!broken && $urandom_range(7) == 0) begin
         extra = $urandom_range(3, 1);
         for (int i = 0; i < extra; i++)
            send_beat(data_beat(p2src_pkg::packed_byte_type'($urandom),
                                base + INDEX_BITS'(i), i == extra - 1));
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_counts.size() == 0) begin
            $error("occurrence_count: no result expected, got %0d", rsp_occurrence_count);
            error_count++;
         end else begin
            oldest_count = pending_counts.pop_front();
            counts_checked++;
            if (rsp_occurrence_count !== oldest_count) begin
               $error("occurrence_count: expected %0d, got %0d", oldest_count,
                      rsp_occurrence_count);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      query_symbol  = '0;
      query_start   = '0;
      query_end     = '0;
      query_primary = '0;
      running_tally = '0;

      directed_beats.push_back(data_beat(8'h00, 38'd0, 1'b1, 1'b1, 40'd0));
      directed_beats.push_back(begin_beat(2'd0, 40'd0, 40'd8, 40'd0));
      directed_beats.push_back(data_beat(8'h00, 38'd0, 1'b0));
      directed_beats.push_back(data_beat(8'h00, 38'd1, 1'b1, 1'b1, 40'd7));
      directed_beats.push_back(begin_beat(2'd3, 40'd1, 40'd7, 40'd2));
      directed_beats.push_back(data_beat(8'hFF, 38'd0, 1'b0));
      directed_beats.push_back(data_beat(8'hFF, 38'd1, 1'b1, 1'b1, 40'd6));
      directed_beats.push_back(begin_beat(2'd1, 40'd0, 40'd0, 40'd0));
      directed_beats.push_back(data_beat(8'h55, 38'd0, 1'b1, 1'b1, 40'd0));
      directed_beats.push_back(begin_beat(2'd2, 40'd10, 40'd4, 40'd5));
      directed_beats.push_back(data_beat(8'hAA, 38'd1, 1'b1, 1'b1, 40'd0));
      directed_beats.push_back(begin_beat(2'd0, 40'd0, 40'd4, 40'd0));
      directed_beats.push_back(data_beat(8'hFF, 38'd0, 1'b1, 1'b1, 40'd0));
      directed_beats.push_back(data_beat(8'h00, 38'd0, 1'b1, 1'b1, 40'd3));
      directed_beats.push_back(begin_beat(2'd2, 40'd8, 40'd12, 40'd99));
      directed_beats.push_back(data_beat(8'hAA, 38'd0, 1'b0));
      directed_beats.push_back(data_beat(8'hAA, 38'd2, 1'b0));
      directed_beats.push_back(data_beat(8'hAA, 38'd2, 1'b0));
      directed_beats.push_back(data_beat(8'hAA, 38'd3, 1'b1));
      directed_beats.push_back(begin_beat(2'd1, POS_MAX - 40'd7, POS_MAX, POS_MAX));
      directed_beats.push_back(data_beat(8'h55, INDEX_MAX, 1'b1));
      directed_beats.push_back(begin_beat(2'd0, 40'd0, POS_MAX, 40'd5));
      directed_beats.push_back(data_beat(8'h00, 38'd1, 1'b0));
      directed_beats.push_back(data_beat(8'hE4, INDEX_MAX, 1'b1));

      reset <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_beats[i])
         send_beat(directed_beats[i]);

      while (beats_sent < directed_beats.size() + RANDOM_BEATS) begin
         steady = beats_sent >= 300 && beats_sent < 450;
         case ($urandom_range(19))
            0, 1:    send_query(1'b1);
            2:       send_beat(data_beat(p2src_pkg::packed_byte_type'($urandom),
                                         random_index(), 1'($urandom)));
            default: send_query(1'b0);
         endcase
      end
      steady = 1'b0;
      req_valid <= 1'b0;

      while (pending_counts.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("Sent %0d beats: %0d queries begun, %0d data bytes.", beats_sent,
               queries_begun, data_beats);
      $display("Checked %0d occurrence counts, %0d mismatches.", counts_checked, error_count);
      if (error_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

[files.f]
+incdir+design
design/p2src_pkg.sv
design/p2src_byte_match.sv
design/packed_2bit_symbol_range_count.sv
verif/tb_packed_2bit_symbol_range_count.sv
